/* rtl/core/sflow_record_walker_core_defines.svh */
// Assertion macros shared by the record walker modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SFLOW_RECORD_WALKER_CORE_DEFINES_SVH
`define SFLOW_RECORD_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SFRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SFRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sfrw_pkg.sv */
`timescale 1ns / 1ps

package sfrw_pkg;

  // Default widths of the length and record count datapaths.
  localparam int DEF_LENGTH_BITS = 16;
  localparam int DEF_COUNT_BITS  = 16;

  // Record header layout: a 32-bit type word and a 32-bit length, big-endian.
  localparam int HDR_BYTES   = 8;
  localparam int FORMAT_BITS = 12;
  localparam logic [31:0] FORMAT_MASK = 32'b00000000000000000000111111111111;

  // Width and reset of the maximum record length register.
  localparam int MAX_LEN_BITS = 16;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 16'hFFFF;

  // Depth of the result queue; a power of two, holding at least two words.
  localparam int RES_DEPTH = 4;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HDR_TRUNC = 3'd1,
    ERR_LEN_LARGE = 3'd2,
    ERR_PAST_END  = 3'd3,
    ERR_TRAILING  = 3'd4
  } err_e;

  // One result word as it is stored in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] record_type;
    logic [15:0] payload_offset;
    logic [15:0] body_len;
    logic        trail_pad;
    err_e        error_code;
    logic        last;
  } result_t;

  // Up to two result words pushed by one input word, in order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    data0;
    result_t    data1;
  } push_t;

endpackage

/* rtl/core/sfrw_in_if.sv */
`timescale 1ns / 1ps

// Input channel: block start words and data bytes.
interface sfrw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] record_count;
  logic [15:0] block_length;
  logic        strict_mode;
  logic [7:0]  data_byte;

  modport source (
    output valid, action, record_count, block_length, strict_mode, data_byte,
    input  ready
  );

  modport sink (
    input  valid, action, record_count, block_length, strict_mode, data_byte,
    output ready
  );
endinterface

/* rtl/core/sfrw_out_if.sv */
`timescale 1ns / 1ps

// Output channel: record descriptors and block end reports.
interface sfrw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] record_type;
  logic [19:0] enterprise;
  logic [11:0] format;
  logic [15:0] payload_offset;
  logic [15:0] body_len;
  logic        trail_pad;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, kind, record_type, enterprise, format, payload_offset,
           body_len, trail_pad, error_code, last,
    input  ready
  );

  modport sink (
    input  valid, kind, record_type, enterprise, format, payload_offset,
           body_len, trail_pad, error_code, last,
    output ready
  );
endinterface

/* rtl/core/sfrw_result_fifo.sv */
`timescale 1ns / 1ps
`include "sflow_record_walker_core_defines.svh"

// Small result queue: takes up to two words per cycle, hands out one while the sink is ready.
module sfrw_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfrw_pkg::push_t     push_i,
  output logic                space_ok_o,
  sfrw_out_if.source          out_o
);

  localparam int Depth = sfrw_pkg::RES_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  sfrw_pkg::result_t mem_q [Depth];
  sfrw_pkg::result_t head;

  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  // Storage writes: the second word lands in the entry after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.data0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.data1;
    end
  end

  // Pointer and fill count update.
  always_comb begin
    pop   = out_o.valid && out_o.ready;
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // The walker may push two words only while two entries are free.
  assign space_ok_o = (cnt_q <= CntW'(Depth - 2));

  // Head of the queue drives the output channel; the type word is split here.
  assign head                 = mem_q[rd_q];
  assign out_o.valid          = (cnt_q != '0);
  assign out_o.kind           = head.kind;
  assign out_o.record_type    = head.record_type;
  assign out_o.enterprise     = head.record_type[31:sfrw_pkg::FORMAT_BITS];
  assign out_o.format         = 12'(head.record_type & sfrw_pkg::FORMAT_MASK);
  assign out_o.payload_offset = head.payload_offset;
  assign out_o.body_len       = head.body_len;
  assign out_o.trail_pad      = head.trail_pad;
  assign out_o.error_code     = head.error_code;
  assign out_o.last           = head.last;

  `SFRW_ASSERT_IMP(a_fifo_no_overflow, 1'b1, cnt_q <= CntW'(Depth), "result queue overflow")
  `SFRW_ASSERT_NEXT(a_fifo_push_shows, push_i.cnt != 2'd0, out_o.valid, "pushed word not visible")

endmodule

/* rtl/core/sfrw_walker.sv */
`timescale 1ns / 1ps
`include "sflow_record_walker_core_defines.svh"

// Record walker: tracks position in the block, gathers record headers,
// checks lengths and builds the result words for each accepted input word.
module sfrw_walker #(
  parameter int LENGTH_BITS = sfrw_pkg::DEF_LENGTH_BITS,
  parameter int COUNT_BITS  = sfrw_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfrw_pkg::MAX_LEN_BITS-1:0] cfg_wdata_i,
  sfrw_in_if.sink                           in_i,
  input  logic                              space_ok_i,
  output sfrw_pkg::push_t                   push_o
);

  localparam int HdrCntW = $clog2(sfrw_pkg::HDR_BYTES);
  localparam int HdrW    = (sfrw_pkg::HDR_BYTES - 1) * 8;

  logic [sfrw_pkg::MAX_LEN_BITS-1:0] max_len_q;

  logic                   active_q, active_d;
  logic                   strict_q, strict_d;
  logic                   in_payload_q, in_payload_d;
  logic [COUNT_BITS-1:0]  rec_left_q, rec_left_d;
  logic [LENGTH_BITS-1:0] size_q, size_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [HdrCntW-1:0]     hdr_cnt_q, hdr_cnt_d;
  logic [HdrW-1:0]        hdr_q, hdr_d;
  logic [sfrw_pkg::MAX_LEN_BITS-1:0] skip_q, skip_d;

  logic                   in_fire;
  logic [COUNT_BITS-1:0]  cnt_start;
  logic [LENGTH_BITS-1:0] size_start;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [31:0]            pos_ext;
  logic [31:0]            left_dec_ext;
  logic [31:0]            type_w;
  logic [31:0]            len_w;

  logic                   bnd_req;
  logic [COUNT_BITS-1:0]  bnd_rl;
  logic [LENGTH_BITS-1:0] bnd_lf;
  sfrw_pkg::result_t      bnd_res;
  logic                   bnd_emit;
  sfrw_pkg::result_t      res0;
  logic [1:0]             n_res;

  logic                   left_match;
  logic                   zero_start;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = space_ok_i;

  // Derived values of the current word.
  assign cnt_start    = COUNT_BITS'(in_i.record_count);
  assign size_start   = LENGTH_BITS'(in_i.block_length);
  assign pos_inc      = pos_q + LENGTH_BITS'(1);
  assign left_dec     = left_q - LENGTH_BITS'(1);
  assign pos_ext      = 32'(pos_inc);
  assign left_dec_ext = 32'(left_dec);
  assign type_w       = hdr_q[HdrW-1 -: 32];
  assign len_w        = {hdr_q[HdrW-33:0], in_i.data_byte};

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sfrw_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Next state and result words for one accepted input word.
  always_comb begin
    active_d     = active_q;
    strict_d     = strict_q;
    in_payload_d = in_payload_q;
    rec_left_d   = rec_left_q;
    size_d       = size_q;
    pos_d        = pos_q;
    left_d       = left_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr_d        = hdr_q;
    skip_d       = skip_q;
    res0         = '0;
    n_res        = 2'd0;
    bnd_req      = 1'b0;
    bnd_rl       = rec_left_q;
    bnd_lf       = left_q;
    bnd_res      = '0;
    bnd_emit     = 1'b0;

    if (in_fire) begin
      if (in_i.action == sfrw_pkg::ACT_START) begin
        // A new block abandons any block in progress.
        active_d     = 1'b1;
        strict_d     = in_i.strict_mode;
        in_payload_d = 1'b0;
        rec_left_d   = cnt_start;
        size_d       = size_start;
        pos_d        = '0;
        left_d       = size_start;
        skip_d       = '0;
        bnd_req      = 1'b1;
        bnd_rl       = cnt_start;
        bnd_lf       = size_start;
      end else if (active_q) begin
        pos_d  = pos_inc;
        left_d = left_dec;
        if (in_payload_q) begin
          // Skipping payload; the last payload byte closes the record.
          skip_d = skip_q - sfrw_pkg::MAX_LEN_BITS'(1);
          if (skip_q == sfrw_pkg::MAX_LEN_BITS'(1)) begin
            in_payload_d = 1'b0;
            rec_left_d   = rec_left_q - COUNT_BITS'(1);
            bnd_req      = 1'b1;
            bnd_rl       = rec_left_q - COUNT_BITS'(1);
            bnd_lf       = left_dec;
          end
        end else if (hdr_cnt_q != HdrCntW'(sfrw_pkg::HDR_BYTES - 1)) begin
          // Gathering the header, most significant byte first.
          hdr_d     = {hdr_q[HdrW-9:0], in_i.data_byte};
          hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
        end else begin
          // Header complete: check the length, then report the record.
          hdr_cnt_d = '0;
          hdr_d     = '0;
          if (len_w > 32'(max_len_q)) begin
            active_d         = 1'b0;
            res0.kind        = sfrw_pkg::KIND_FAIL;
            res0.error_code  = sfrw_pkg::ERR_LEN_LARGE;
            res0.last        = 1'b1;
            n_res            = 2'd1;
          end else if (len_w > left_dec_ext) begin
            active_d         = 1'b0;
            res0.kind        = sfrw_pkg::KIND_FAIL;
            res0.error_code  = sfrw_pkg::ERR_PAST_END;
            res0.last        = 1'b1;
            n_res            = 2'd1;
          end else begin
            res0.kind           = sfrw_pkg::KIND_RECORD;
            res0.record_type    = type_w;
            res0.payload_offset = pos_ext[15:0];
            res0.body_len       = len_w[15:0];
            n_res               = 2'd1;
            if (len_w == 32'd0) begin
              // Empty payload closes the record at once.
              rec_left_d = rec_left_q - COUNT_BITS'(1);
              bnd_req    = 1'b1;
              bnd_rl     = rec_left_q - COUNT_BITS'(1);
              bnd_lf     = left_dec;
            end else begin
              skip_d       = len_w[sfrw_pkg::MAX_LEN_BITS-1:0];
              in_payload_d = 1'b1;
            end
          end
        end
      end
    end

    // Record boundary: finish when the count is reached, else check header room.
    if (bnd_req) begin
      hdr_cnt_d = '0;
      hdr_d     = '0;
      if (bnd_rl == '0) begin
        active_d      = 1'b0;
        bnd_emit      = 1'b1;
        bnd_res.last  = 1'b1;
        if (bnd_lf == '0) begin
          bnd_res.kind = sfrw_pkg::KIND_DONE;
        end else if (strict_d) begin
          bnd_res.kind       = sfrw_pkg::KIND_FAIL;
          bnd_res.error_code = sfrw_pkg::ERR_TRAILING;
        end else begin
          bnd_res.kind      = sfrw_pkg::KIND_DONE;
          bnd_res.trail_pad = 1'b1;
        end
      end else if (strict_d ? (32'(bnd_lf) <= 32'(sfrw_pkg::HDR_BYTES))
                            : (32'(bnd_lf) <  32'(sfrw_pkg::HDR_BYTES))) begin
        active_d           = 1'b0;
        in_payload_d       = 1'b0;
        bnd_emit           = 1'b1;
        bnd_res.kind       = sfrw_pkg::KIND_FAIL;
        bnd_res.error_code = sfrw_pkg::ERR_HDR_TRUNC;
        bnd_res.last       = 1'b1;
      end
    end

    // Order the words: a record descriptor always comes first.
    push_o.data0 = res0;
    push_o.data1 = '0;
    push_o.cnt   = n_res;
    if (bnd_emit) begin
      if (n_res == 2'd0) begin
        push_o.data0 = bnd_res;
      end else begin
        push_o.data1 = bnd_res;
      end
      push_o.cnt = n_res + 2'd1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      strict_q     <= 1'b0;
      in_payload_q <= 1'b0;
      rec_left_q   <= '0;
      size_q       <= '0;
      pos_q        <= '0;
      left_q       <= '0;
      hdr_cnt_q    <= '0;
      skip_q       <= '0;
    end else begin
      active_q     <= active_d;
      strict_q     <= strict_d;
      in_payload_q <= in_payload_d;
      rec_left_q   <= rec_left_d;
      size_q       <= size_d;
      pos_q        <= pos_d;
      left_q       <= left_d;
      hdr_cnt_q    <= hdr_cnt_d;
      skip_q       <= skip_d;
    end
  end

  // Header shift register: holds the gathered header bytes and has no reset.
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  // Terms watched by the checks below.
  assign left_match = (left_q == LENGTH_BITS'(size_q - pos_q));
  assign zero_start = in_fire && (in_i.action == sfrw_pkg::ACT_START) && (cnt_start == '0);

  `SFRW_ASSERT_IMP(a_payload_needs_active, in_payload_q, active_q, "payload skip outside a block")
  `SFRW_ASSERT_IMP(a_left_tracks_pos, active_q, left_match, "bytes left out of step")
  `SFRW_ASSERT_IMP(a_zero_count_result, zero_start, push_o.cnt == 2'd1, "no end for empty block")

endmodule

/* rtl/core/sflow_record_walker_core.sv */
`timescale 1ns / 1ps
// Result words pass through the result queue and reach the output once the words ahead of them are taken.
// Throughput: one input word per cycle while input ready is high; a word with an empty payload may yield two results.
// Input ready drops only while the four-entry result queue has fewer than two free entries.
// Reset (rst_ni low, asynchronous) ends any block, empties the queue and sets the
// maximum record length to 65535; no clearing pass follows.
module sflow_record_walker_core #(
  parameter int LENGTH_BITS = sfrw_pkg::DEF_LENGTH_BITS,
  parameter int COUNT_BITS  = sfrw_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfrw_pkg::MAX_LEN_BITS-1:0] cfg_wdata_i,
  sfrw_in_if.sink                           in_i,
  sfrw_out_if.source                        out_o
);

  sfrw_pkg::push_t push;
  logic            space_ok;

  // Block walker: state and result building.
  sfrw_walker #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  // Result queue toward the output channel.
  sfrw_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

endmodule

/* sim/sflow_record_walker_core_tb.sv */
`timescale 1ns / 1ps

module sflow_record_walker_core_tb;
  import sfrw_pkg::*;

  // One result word as the walker should report it.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] rtype;
    logic [19:0] enterprise;
    logic [11:0] format;
    logic [15:0] offset;
    logic [15:0] length;
    logic        pad;
    err_e        err;
    logic        last;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [MAX_LEN_BITS-1:0] cfg_wdata_i;

  sfrw_in_if  in_bus ();
  sfrw_out_if out_bus ();

  sflow_record_walker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Walker state as the testbench tracks it.
  logic [15:0] max_len = MAX_LEN_RESET;
  logic        walk_active = 1'b0;
  logic        walk_strict = 1'b0;
  logic [15:0] recs_expected = '0;
  logic [15:0] recs_seen = '0;
  logic [15:0] blk_len = '0;
  logic [15:0] blk_pos = '0;
  logic [63:0] hdr_acc = '0;
  logic [3:0]  hdr_count = '0;
  logic [15:0] skip_left = '0;
  logic        skipping = 1'b0;

  report_t     expected_reports[$];
  int unsigned live_items = 0;
  int unsigned fail_count = 0;
  logic        calm_mode = 1'b0;

  // Appends one expected result word.
  task automatic queue_report(input kind_e kind, input logic [31:0] rtype,
                              input logic [15:0] offset, input logic [15:0] length,
                              input logic pad, input err_e err, input logic last);
    report_t r;
    r.kind       = kind;
    r.rtype      = rtype;
    r.enterprise = rtype[31:FORMAT_BITS];
    r.format     = rtype[FORMAT_BITS-1:0] & FORMAT_MASK[FORMAT_BITS-1:0];
    r.offset     = offset;
    r.length     = length;
    r.pad        = pad;
    r.err        = err;
    r.last       = last;
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic abort_block(input err_e err);
    walk_active = 1'b0;
    skipping    = 1'b0;
    queue_report(KIND_FAIL, '0, '0, '0, 1'b0, err, 1'b1);
  endtask

  // At the start of a block and after each record: finish, or check room for a header.
  task automatic close_record();
    logic [31:0] left;
    left      = {16'b0, blk_len} - {16'b0, blk_pos};
    hdr_acc   = '0;
    hdr_count = '0;
    if (recs_seen == recs_expected) begin
      walk_active = 1'b0;
      if (left == 0) begin
        queue_report(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE, 1'b1);
      end else if (walk_strict) begin
        abort_block(ERR_TRAILING);
      end else begin
        queue_report(KIND_DONE, '0, '0, '0, 1'b1, ERR_NONE, 1'b1);
      end
    end else if (walk_strict ? (left <= HDR_BYTES) : (left < HDR_BYTES)) begin
      abort_block(ERR_HDR_TRUNC);
    end
  endtask

  // Advances the tracked walker by one accepted input word.
  task automatic walk_word(input action_e act, input logic [15:0] cnt,
                           input logic [15:0] blen, input logic strict, input logic [7:0] b);
    logic [31:0] rtype;
    logic [31:0] rlen;
    logic [32:0] reach;
    if (act == ACT_START) begin
      live_items++;
      recs_expected = cnt;
      blk_len       = blen;
      walk_strict   = strict;
      recs_seen     = '0;
      blk_pos       = '0;
      skip_left     = '0;
      skipping      = 1'b0;
      walk_active   = 1'b1;
      close_record();
    end else if (walk_active) begin
      live_items++;
      blk_pos = blk_pos + 16'd1;
      if (skipping) begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          skipping  = 1'b0;
          recs_seen = recs_seen + 16'd1;
          close_record();
        end
      end else begin
        hdr_acc   = {hdr_acc[55:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == HDR_BYTES) begin
          rtype     = hdr_acc[63:32];
          rlen      = hdr_acc[31:0];
          hdr_acc   = '0;
          hdr_count = '0;
          reach     = {1'b0, rlen} + {17'b0, blk_pos};
          if (rlen > {16'b0, max_len}) begin
            abort_block(ERR_LEN_LARGE);
          end else if (reach > {17'b0, blk_len}) begin
            abort_block(ERR_PAST_END);
          end else begin
            queue_report(KIND_RECORD, rtype, blk_pos, rlen[15:0], 1'b0, ERR_NONE, 1'b0);
            if (rlen == 0) begin
              recs_seen = recs_seen + 16'd1;
              close_record();
            end else begin
              skip_left = rlen[15:0];
              skipping  = 1'b1;
            end
          end
        end
      end
    end
  endtask

  // Offers one word, with random idle cycles before it, and tracks it once accepted.
  task automatic send_word(input action_e act, input logic [15:0] cnt,
                           input logic [15:0] blen, input logic strict, input logic [7:0] b);
    int unsigned idle;
    idle = 0;
    while (!calm_mode && $urandom_range(99) < 13) idle++;
    if (idle != 0) begin
      in_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= act;
    in_bus.record_count <= cnt;
    in_bus.block_length <= blen;
    in_bus.strict_mode  <= strict;
    in_bus.data_byte    <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    walk_word(act, cnt, blen, strict, b);
  endtask

  // Sends the eight header bytes of one record, big-endian.
  task automatic send_header(input logic [31:0] rtype, input logic [31:0] rlen);
    logic [63:0] hdr;
    hdr = {rtype, rlen};
    for (int s = 56; s >= 0; s -= 8) begin
      send_word(ACT_DATA, 16'h0000, 16'h0000, 1'b0, hdr[s +: 8]);
    end
  endtask

  // Stops offering words, then waits for every expected result.
  task automatic drain_reports();
    in_bus.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_length(input logic [15:0] value);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len = value;
  endtask

  // Random blocks: mostly well formed, some cut short, mislabeled or abandoned.
  task automatic run_block_traffic(input int unsigned n_items);
    logic [7:0]  body[$];
    logic [31:0] rtype;
    logic [31:0] rlen;
    logic [31:0] noise;
    logic [15:0] blen;
    logic [15:0] cnt;
    logic        strict;
    int unsigned goal;
    int unsigned n_rec;
    int unsigned pad;
    int unsigned pick;
    int unsigned cut;
    int unsigned sent_len;
    goal = live_items + n_items;
    while (live_items < goal) begin
      body.delete();
      n_rec  = $urandom_range(0, 4);
      strict = ($urandom_range(1) == 1);
      for (int i = 0; i < n_rec; i++) begin
        rtype = $urandom();
        pick  = $urandom_range(99);
        if (pick < 30) rlen = 0;
        else if (pick < 95) rlen = $urandom_range(1, 12);
        else rlen = $urandom_range(13, 300);
        if ($urandom_range(99) < 4) rlen = $urandom();
        for (int s = 24; s >= 0; s -= 8) body.insert(body.size(), rtype[s +: 8]);
        for (int s = 24; s >= 0; s -= 8) body.insert(body.size(), rlen[s +: 8]);
        if (rlen <= 300) begin
          for (int j = 0; j < rlen; j++) begin
            noise = $urandom();
            body.insert(body.size(), noise[7:0]);
          end
        end
      end
      pad = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 9);
      for (int j = 0; j < pad; j++) begin
        noise = $urandom();
        body.insert(body.size(), noise[7:0]);
      end
      blen     = 16'(body.size());
      cnt      = 16'(n_rec);
      sent_len = body.size();
      pick     = $urandom_range(99);
      noise    = $urandom();
      if (pick < 8) begin
        cut  = $urandom_range(1, 10);
        blen = (blen > cut) ? blen - 16'(cut) : 16'd0;
      end else if (pick < 13) begin
        cnt = cnt + 16'd1;
      end else if (pick < 16) begin
        cnt = noise[15:0];
      end else if (pick < 19) begin
        blen = noise[31:16];
      end else if (pick < 25) begin
        sent_len = $urandom_range(0, body.size());
      end else if (pick < 29) begin
        cut = $urandom_range(1, 4);
        for (int j = 0; j < cut; j++) begin
          noise = $urandom();
          body.insert(body.size(), noise[7:0]);
        end
        sent_len = body.size();
      end
      noise = $urandom();
      send_word(ACT_START, cnt, blen, strict, noise[7:0]);
      for (int i = 0; i < sent_len; i++) begin
        noise = $urandom();
        send_word(ACT_DATA, noise[15:0], noise[31:16], noise[8], body[i]);
      end
    end
    drain_reports();
  endtask

  // Block starts that end or fail at once, and a byte with no block open.
  task automatic test_block_edges();
    send_word(ACT_START, 16'd0, 16'd0, 1'b0, 8'h00);
    send_word(ACT_START, 16'd0, 16'd5, 1'b0, 8'hFF);
    send_word(ACT_START, 16'd0, 16'hFFFF, 1'b1, 8'h00);
    send_word(ACT_START, 16'd1, 16'd8, 1'b1, 8'h00);
    send_word(ACT_START, 16'hFFFF, 16'd7, 1'b0, 8'h00);
    send_word(ACT_DATA, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    drain_reports();
  endtask

  // An empty payload yields the descriptor and the block end from the same byte.
  task automatic test_empty_payload();
    send_word(ACT_START, 16'd1, 16'd8, 1'b0, 8'h00);
    send_header(32'hFFFF_FFFF, 32'd0);
    drain_reports();
  endtask

  // A new start abandons an open block; the new block then runs past its end.
  task automatic test_restart_past_end();
    send_word(ACT_START, 16'd3, 16'hFFFF, 1'b1, 8'h00);
    send_word(ACT_DATA, 16'h0000, 16'h0000, 1'b0, 8'hA5);
    send_word(ACT_START, 16'd1, 16'd9, 1'b0, 8'h00);
    send_header(32'h0001_0000, 32'd2);
    drain_reports();
  endtask

  // A length one above the reset limit is rejected.
  task automatic test_length_limit();
    send_word(ACT_START, 16'd1, 16'd16, 1'b0, 8'h00);
    send_header(32'h1234_5ABC, 32'h0001_0000);
    drain_reports();
  endtask

  task automatic test_walk_full_limit();
    set_max_length(16'hFFFF);
    run_block_traffic(500);
  endtask

  // With a zero limit only empty payloads pass.
  task automatic test_walk_zero_limit();
    set_max_length(16'h0000);
    run_block_traffic(200);
  endtask

  task automatic test_walk_tight_limit();
    set_max_length(16'($urandom_range(1, 12)));
    run_block_traffic(400);
    set_max_length(16'($urandom_range(1, 6)));
    run_block_traffic(200);
  endtask

  // Neither side idles during the calm run, so words stream back to back while the queue has room.
  task automatic test_walk_no_stalls();
    logic [31:0] noise;
    noise = $urandom();
    set_max_length(noise[15:0]);
    calm_mode = 1'b1;
    run_block_traffic(300);
    calm_mode = 1'b0;
    set_max_length(16'hFFFF);
    run_block_traffic(200);
  endtask

  // The result sink stalls at random unless the calm stretch is on.
  always @(posedge clk_i) begin
    out_bus.ready <= calm_mode || ($urandom_range(99) >= 13);
  end

  // Compares each accepted result word with the oldest expected one.
  always @(posedge clk_i) begin : check_reports
    report_t want;
    report_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.kind       = kind_e'(out_bus.kind);
      got.rtype      = out_bus.record_type;
      got.enterprise = out_bus.enterprise;
      got.format     = out_bus.format;
      got.offset     = out_bus.payload_offset;
      got.length     = out_bus.body_len;
      got.pad        = out_bus.trail_pad;
      got.err        = err_e'(out_bus.error_code);
      got.last       = out_bus.last;
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result word with none expected: kind=%0d type=%h err=%0d",
                   $realtime, got.kind, got.rtype, got.err);
        end
      end else begin
        want = expected_reports.pop_front();
        if (got.kind !== want.kind || got.rtype !== want.rtype ||
            got.enterprise !== want.enterprise || got.format !== want.format ||
            got.offset !== want.offset || got.length !== want.length ||
            got.pad !== want.pad || got.err !== want.err || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $write("%0t: expected kind=%0d type=%h ent=%h fmt=%h",
                   $realtime, want.kind, want.rtype, want.enterprise, want.format);
            $display(" off=%0d len=%0d pad=%b err=%0d last=%b",
                     want.offset, want.length, want.pad, want.err, want.last);
            $write("%0t: actual   kind=%0d type=%h ent=%h fmt=%h",
                   $realtime, got.kind, got.rtype, got.enterprise, got.format);
            $display(" off=%0d len=%0d pad=%b err=%0d last=%b",
                     got.offset, got.length, got.pad, got.err, got.last);
          end
        end
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_START;
    in_bus.record_count = '0;
    in_bus.block_length = '0;
    in_bus.strict_mode  = 1'b0;
    in_bus.data_byte    = '0;
    out_bus.ready       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_block_edges();
    test_empty_payload();
    test_restart_past_end();
    test_length_limit();
    test_walk_full_limit();
    test_walk_zero_limit();
    test_walk_tight_limit();
    test_walk_no_stalls();

    drain_reports();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
